// ----- design/puv_pkg.sv -----
// Shared types and constants for the path validator.
// No dependencies; imported by path_utf8_validator and its testbench.
package puv_pkg;

	localparam int PUV_MAX_PATH_LEN = 256;
	localparam int PUV_MAX_SEG_LEN  = 128;
	localparam int PUV_PREFIX_LEN   = 5;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DEL    = 8'h7f;

	localparam logic [20:0] CP_MIN_2B    = 21'h000080;
	localparam logic [20:0] CP_MIN_3B    = 21'h000800;
	localparam logic [20:0] CP_MIN_4B    = 21'h010000;
	localparam logic [20:0] CP_MAX       = 21'h10ffff;
	localparam logic [20:0] CP_SURR_LO   = 21'h00d800;
	localparam logic [20:0] CP_SURR_HI   = 21'h00dfff;

	localparam logic [1:0] MIN_CLASS_2B = 2'd1;
	localparam logic [1:0] MIN_CLASS_3B = 2'd2;
	localparam logic [1:0] MIN_CLASS_4B = 2'd3;

	typedef struct packed {
		logic [7:0] path_byte;
		logic       last_byte;
	} puv_in_t;

	typedef struct packed {
		logic       path_valid;
		logic [7:0] segment_count;
	} puv_out_t;

	// Reserved segment prefix, one byte per position.
	function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
		logic [7:0] r;
		begin
			case (idx)
				3'd0:    r = 8'h2e;
				3'd1:    r = 8'h70;
				3'd2:    r = 8'h78;
				3'd3:    r = 8'h61;
				3'd4:    r = 8'h2d;
				default: r = 8'h00;
			endcase
			return r;
		end
	endfunction

endpackage

// ----- design/path_utf8_validator.sv -----
// Path validator: per-byte segment, character and UTF-8 rule checks.
// Depends on puv_pkg.
// The verdict is registered in the result register once the last byte of a path has
// passed the input register and any earlier verdict has been taken by out_ready.
// Throughput: one byte per cycle; the input register, the running state and the
// result register each take one step per cycle. A verdict held by out_ready stalls
// only the final byte of the next path, which waits in the input register.
// Reset (arst_n low, asynchronous) clears all running path state and both valids.
module path_utf8_validator #(
	parameter int MAX_PATH_LEN    = puv_pkg::PUV_MAX_PATH_LEN,
	parameter int MAX_SEGMENT_LEN = puv_pkg::PUV_MAX_SEG_LEN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  puv_pkg::puv_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output puv_pkg::puv_out_t out_data
);
	import puv_pkg::*;

	localparam int BS_W = $clog2(MAX_PATH_LEN + 2);
	localparam int SL_W = $clog2(MAX_SEGMENT_LEN + 2);
	localparam logic [BS_W-1:0] BS_MAX = BS_W'(MAX_PATH_LEN);
	localparam logic [SL_W-1:0] SL_MAX = SL_W'(MAX_SEGMENT_LEN);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;

	// running state
	logic [BS_W-1:0] bytes_seen_q;
	logic [SL_W-1:0] seg_len_q;
	logic [7:0]      segs_q;
	logic [1:0]      cont_q;
	logic [20:0]     acc_q;
	logic [1:0]      min_class_q;
	logic [2:0]      prefix_q;
	logic            failed_q;
	logic            dots_q;

	logic            out_valid_q;
	puv_out_t        out_q;

	// next-state values
	logic [BS_W-1:0] bs_n;
	logic [SL_W-1:0] sl_n;
	logic [7:0]      segs_n;
	logic [1:0]      cont_n;
	logic [20:0]     acc_n;
	logic [20:0]     acc_shift;
	logic [20:0]     cp_min;
	logic [1:0]      min_n;
	logic [2:0]      prefix_n;
	logic            fail_n;
	logic            dots_n;
	logic            is_slash;
	logic            end_seg;

	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_comb begin
		is_slash  = (byte_s1 == CH_SLASH);
		end_seg   = is_slash || last_s1;
		bs_n      = bytes_seen_q;
		sl_n      = seg_len_q;
		segs_n    = segs_q;
		cont_n    = cont_q;
		acc_n     = acc_q;
		min_n     = min_class_q;
		prefix_n  = prefix_q;
		fail_n    = failed_q;
		dots_n    = dots_q;
		acc_shift = {acc_q[14:0], byte_s1[5:0]};
		cp_min    = (min_class_q == MIN_CLASS_2B) ? CP_MIN_2B :
		            (min_class_q == MIN_CLASS_3B) ? CP_MIN_3B : CP_MIN_4B;

		if (bytes_seen_q <= BS_MAX)
			bs_n = bytes_seen_q + 1'b1;
		if (bs_n > BS_MAX)
			fail_n = 1'b1;

		if (!is_slash) begin
			if (seg_len_q < SL_W'(PUV_PREFIX_LEN) && SL_W'(prefix_q) == seg_len_q &&
			    byte_s1 == prefix_byte(prefix_q)) begin
				prefix_n = prefix_q + 3'd1;
				if (prefix_n == 3'(PUV_PREFIX_LEN))
					fail_n = 1'b1;
			end
			if (byte_s1 != CH_DOT)
				dots_n = 1'b0;
			if (seg_len_q <= SL_MAX)
				sl_n = seg_len_q + 1'b1;

			if (cont_q != 2'd0) begin
				if (byte_s1[7:6] != 2'b10) begin
					fail_n = 1'b1;
					cont_n = 2'd0;
				end else begin
					acc_n  = acc_shift;
					cont_n = cont_q - 2'd1;
					if (cont_n == 2'd0 && (acc_shift < cp_min || acc_shift > CP_MAX ||
					    (acc_shift >= CP_SURR_LO && acc_shift <= CP_SURR_HI)))
						fail_n = 1'b1;
				end
			end else if (byte_s1 inside {[8'h00:8'h7f]}) begin
				if (byte_s1 < CH_SPACE || byte_s1 == CH_DEL || byte_s1 == CH_BSLASH)
					fail_n = 1'b1;
			end else if (byte_s1 inside {[8'hc0:8'hdf]}) begin
				acc_n  = {16'd0, byte_s1[4:0]};
				min_n  = MIN_CLASS_2B;
				cont_n = 2'd1;
			end else if (byte_s1 inside {[8'he0:8'hef]}) begin
				acc_n  = {17'd0, byte_s1[3:0]};
				min_n  = MIN_CLASS_3B;
				cont_n = 2'd2;
			end else if (byte_s1 inside {[8'hf0:8'hf7]}) begin
				acc_n  = {18'd0, byte_s1[2:0]};
				min_n  = MIN_CLASS_4B;
				cont_n = 2'd3;
			end else begin
				fail_n = 1'b1;
			end
		end

		// a trailing slash has already closed its segment; it just fails the path
		if (last_s1 && is_slash)
			fail_n = 1'b1;
		if (end_seg) begin
			if (sl_n == '0 || sl_n > SL_MAX)
				fail_n = 1'b1;
			if (dots_n && sl_n <= SL_W'(2))
				fail_n = 1'b1;
			if (cont_n != 2'd0)
				fail_n = 1'b1;
			if (segs_q != 8'hff)
				segs_n = segs_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_data.path_byte;
			last_s1 <= in_data.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			seg_len_q    <= '0;
			segs_q       <= '0;
			cont_q       <= '0;
			acc_q        <= '0;
			min_class_q  <= '0;
			prefix_q     <= '0;
			failed_q     <= 1'b0;
			dots_q       <= 1'b1;
		end else if (adv_s1) begin
			if (last_s1 || end_seg) begin
				seg_len_q   <= '0;
				cont_q      <= '0;
				acc_q       <= '0;
				min_class_q <= '0;
				prefix_q    <= '0;
				dots_q      <= 1'b1;
			end else begin
				seg_len_q   <= sl_n;
				cont_q      <= cont_n;
				acc_q       <= acc_n;
				min_class_q <= min_n;
				prefix_q    <= prefix_n;
				dots_q      <= dots_n;
			end
			if (last_s1) begin
				bytes_seen_q <= '0;
				segs_q       <= '0;
				failed_q     <= 1'b0;
			end else begin
				bytes_seen_q <= bs_n;
				segs_q       <= segs_n;
				failed_q     <= fail_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_q.path_valid    <= !fail_n;
			out_q.segment_count <= fail_n ? 8'd0 : segs_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- sim/tb_path_utf8_validator.sv -----
// Self-checking testbench for path_utf8_validator: directed corner paths, then random paths.
// Depends on puv_pkg and path_utf8_validator; a built-in predictor tracks expected verdicts.
`timescale 1ns / 100ps

module tb_path_utf8_validator;
	import puv_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	// directed paths add about 1240 bytes ahead of the random ones
	localparam int RANDOM_ITEMS = 610;

	localparam logic [8:0]  PATH_CAP = 9'(PUV_MAX_PATH_LEN);
	localparam logic [7:0]  SEG_CAP  = 8'(PUV_MAX_SEG_LEN);
	// reserved segment prefix, byte 0 in the low bits
	localparam logic [39:0] RESERVED_PREFIX = {8'h2d, 8'h61, 8'h78, 8'h70, 8'h2e};

	typedef enum logic [3:0] {
		F_NONE, F_CTRL, F_RAW, F_STRAY_CONT, F_TRUNC, F_OVERLONG, F_SURROGATE,
		F_TOO_HIGH, F_EMPTY_SEG, F_LEAD_SLASH, F_TRAIL_SLASH, F_PREFIX, F_DOTS
	} fault_e;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	puv_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	puv_out_t out_data;

	puv_in_t    pending_bytes[$];
	puv_out_t   expected_verdicts[$];
	logic [7:0] path_buf[$];
	int         mismatches = 0;
	int         cycle_n = 0;
	logic       gaps_on;

	// predictor state for the path in flight
	logic [8:0]  bytes_seen = '0;
	logic [7:0]  seg_len = '0;
	logic [7:0]  seg_total = '0;
	logic [1:0]  cont_left = '0;
	logic [20:0] cp_acc = '0;
	logic [1:0]  min_class = '0;
	logic [2:0]  prefix_hits = '0;
	logic        failed = 1'b0;
	logic        prev_slash = 1'b0;
	logic        dots_only = 1'b1;

	path_utf8_validator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// quiet window: no gaps on either side
	assign gaps_on = !(cycle_n >= 1500 && cycle_n < 2500);

	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic seg_close();
		if (seg_len == 8'd0 || seg_len > SEG_CAP)
			failed = 1'b1;
		if (dots_only && seg_len <= 8'd2)
			failed = 1'b1;
		if (cont_left != 2'd0)
			failed = 1'b1;
		if (seg_total != 8'd255)
			seg_total++;
		seg_len = '0;
		cont_left = '0;
		cp_acc = '0;
		min_class = '0;
		prefix_hits = '0;
		dots_only = 1'b1;
	endtask

	task automatic seg_take(input logic [7:0] b);
		logic [20:0] floor_cp;
		if (seg_len < 8'd5 && prefix_hits == seg_len[2:0] &&
				b == RESERVED_PREFIX[{seg_len[2:0], 3'b000} +: 8]) begin
			prefix_hits++;
			if (prefix_hits == 3'd5)
				failed = 1'b1;
		end
		if (b != CH_DOT)
			dots_only = 1'b0;
		if (seg_len <= SEG_CAP)
			seg_len++;
		if (cont_left != 2'd0) begin
			if (b[7:6] != 2'b10) begin
				failed = 1'b1;
				cont_left = '0;
			end else begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				cont_left--;
				if (cont_left == 2'd0) begin
					floor_cp = (min_class == MIN_CLASS_2B) ? CP_MIN_2B :
						(min_class == MIN_CLASS_3B) ? CP_MIN_3B : CP_MIN_4B;
					if (cp_acc < floor_cp || cp_acc > CP_MAX ||
							(cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI))
						failed = 1'b1;
				end
			end
		end else if (!b[7]) begin
			if (b < CH_SPACE || b == CH_DEL || b == CH_BSLASH)
				failed = 1'b1;
		end else if (b[7:5] == 3'b110) begin
			cp_acc = {16'd0, b[4:0]};
			min_class = MIN_CLASS_2B;
			cont_left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			cp_acc = {17'd0, b[3:0]};
			min_class = MIN_CLASS_3B;
			cont_left = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			cp_acc = {18'd0, b[2:0]};
			min_class = MIN_CLASS_4B;
			cont_left = 2'd3;
		end else
			failed = 1'b1;
	endtask

	task automatic track_byte(input puv_in_t item);
		puv_out_t verdict;
		if (bytes_seen <= PATH_CAP)
			bytes_seen++;
		if (bytes_seen > PATH_CAP)
			failed = 1'b1;
		if (item.path_byte == CH_SLASH)
			seg_close();
		else
			seg_take(item.path_byte);
		prev_slash = (item.path_byte == CH_SLASH);
		if (item.last_byte) begin
			if (prev_slash)
				failed = 1'b1;
			else
				seg_close();
			verdict.path_valid = !failed;
			verdict.segment_count = failed ? 8'd0 : seg_total;
			expected_verdicts.push_back(verdict);
			bytes_seen = '0;
			seg_total = '0;
			failed = 1'b0;
			prev_slash = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				track_byte(in_data);
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && !(gaps_on && $urandom_range(99, 0) < 6)) begin
					in_valid <= 1'b1;
					in_data <= pending_bytes.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : verdict_check
		puv_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: verdict with none expected: path_valid=%0b segment_count=%0d",
						$time, out_data.path_valid, out_data.segment_count);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (out_data.path_valid !== want.path_valid) begin
						$display("%0t: path_valid expected %0b, got %0b",
							$time, want.path_valid, out_data.path_valid);
						mismatches++;
					end
					if (out_data.segment_count !== want.segment_count) begin
						$display("%0t: segment_count expected %0d, got %0d",
							$time, want.segment_count, out_data.segment_count);
						mismatches++;
					end
				end
			end
			out_ready <= !(gaps_on && $urandom_range(99, 0) < 6);
		end
	end

	// printable ASCII with both separators kept out
	function automatic logic [7:0] rand_plain();
		logic [7:0] c;
		c = 8'($urandom_range(8'h7e, 8'h20));
		if (c == CH_SLASH || c == CH_BSLASH)
			c = 8'h5f;
		return c;
	endfunction

	task automatic push_utf8(input logic [20:0] cp, input int n);
		case (n)
			2: begin
				path_buf.push_back({3'b110, cp[10:6]});
				path_buf.push_back({2'b10, cp[5:0]});
			end
			3: begin
				path_buf.push_back({4'b1110, cp[15:12]});
				path_buf.push_back({2'b10, cp[11:6]});
				path_buf.push_back({2'b10, cp[5:0]});
			end
			default: begin
				path_buf.push_back({5'b11110, cp[20:18]});
				path_buf.push_back({2'b10, cp[17:12]});
				path_buf.push_back({2'b10, cp[11:6]});
				path_buf.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic add_char();
		logic [20:0] cp;
		case ($urandom_range(9, 0))
			0, 1: push_utf8(21'($urandom_range(21'h7ff, 21'h80)), 2);
			2: begin
				cp = 21'($urandom_range(21'hffff, 21'h800));
				// steer out of the surrogate range
				if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
					cp = cp ^ 21'h4000;
				push_utf8(cp, 3);
			end
			3: push_utf8(21'($urandom_range(21'h10ffff, 21'h10000)), 4);
			default: path_buf.push_back(rand_plain());
		endcase
	endtask

	task automatic add_prefix(input int k);
		for (int i = 0; i < k; i++)
			path_buf.push_back(RESERVED_PREFIX[i*8 +: 8]);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			path_buf.push_back(s[i]);
	endtask

	task automatic add_run(input int n);
		repeat (n) path_buf.push_back(rand_plain());
	endtask

	task automatic flush_path();
		puv_in_t item;
		foreach (path_buf[i]) begin
			item.path_byte = path_buf[i];
			item.last_byte = (i == path_buf.size() - 1);
			pending_bytes.push_back(item);
		end
		path_buf.delete();
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int nseg, nchar, pos, fault_at, n, random_fed;
		logic paused;
		fault_e fault;
		logic [20:0] cp;
		random_fed = 0;
		paused = 1'b0;

		add_text("a/b"); flush_path();
		add_text("/a"); flush_path();
		add_text("a/"); flush_path();
		add_text("."); flush_path();
		add_text(".."); flush_path();
		add_text("..."); flush_path();
		add_prefix(5); flush_path();
		path_buf.push_back(8'h00); flush_path();    // NUL
		path_buf.push_back(CH_DEL); flush_path();
		path_buf.push_back(CH_BSLASH); flush_path();
		path_buf.push_back(8'hff); flush_path();
		push_utf8(21'h0, 2); flush_path();          // overlong
		push_utf8(CP_SURR_LO, 3); flush_path();
		push_utf8(CP_MAX + 21'd1, 4); flush_path();
		push_utf8(21'h20ac, 3); void'(path_buf.pop_back()); flush_path();
		add_text(" ~"); push_utf8(CP_MAX, 4); flush_path();
		wait_drained();

		// length corners: full path, one byte over, long segment, most segments, saturation
		add_run(128); path_buf.push_back(CH_SLASH); add_run(127); flush_path();
		add_run(128); path_buf.push_back(CH_SLASH); add_run(128); flush_path();
		add_run(129); flush_path();
		for (int k = 0; k < 128; k++) begin
			if (k != 0)
				path_buf.push_back(CH_SLASH);
			path_buf.push_back(8'h61 + 8'($urandom_range(25, 0)));
		end
		flush_path();
		add_run(300); flush_path();

		while (random_fed < RANDOM_ITEMS) begin
			if ($urandom_range(99, 0) < 8) begin
				repeat ($urandom_range(12, 1)) path_buf.push_back(8'($urandom_range(255, 0)));
			end else begin
				nseg = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
				fault = ($urandom_range(99, 0) < 30) ?
					fault_e'($urandom_range(F_DOTS, F_CTRL)) : F_NONE;
				fault_at = $urandom_range(nseg - 1, 0);
				if (fault == F_LEAD_SLASH)
					path_buf.push_back(CH_SLASH);
				for (int s = 0; s < nseg; s++) begin
					if (s != 0)
						path_buf.push_back(CH_SLASH);
					if (s == fault_at && fault == F_EMPTY_SEG)
						path_buf.push_back(CH_SLASH);
					if (s == fault_at && fault == F_DOTS) begin
						repeat ($urandom_range(3, 1)) path_buf.push_back(CH_DOT);
					end else if (s == fault_at && fault == F_PREFIX) begin
						add_prefix($urandom_range(5, 1));
						repeat ($urandom_range(3, 0)) add_char();
					end else begin
						nchar = $urandom_range(6, 1);
						pos = (s == fault_at) ? $urandom_range(nchar, 0) : -1;
						for (int c = 0; c <= nchar; c++) begin
							if (c == pos) begin
								case (fault)
									F_CTRL: case ($urandom_range(2, 0))
										0: path_buf.push_back(8'($urandom_range(31, 0)));
										1: path_buf.push_back(CH_DEL);
										default: path_buf.push_back(CH_BSLASH);
									endcase
									F_RAW: path_buf.push_back(8'($urandom_range(255, 0)));
									F_STRAY_CONT: path_buf.push_back(8'($urandom_range(8'hbf, 8'h80)));
									F_TRUNC: begin
										n = $urandom_range(4, 2);
										push_utf8(21'($urandom), n);
										repeat ($urandom_range(n - 1, 1)) void'(path_buf.pop_back());
									end
									F_OVERLONG: begin
										n = $urandom_range(4, 2);
										cp = 21'($urandom_range((n == 2) ? 21'h7f :
											(n == 3) ? 21'h7ff : 21'hffff, 0));
										push_utf8(cp, n);
									end
									F_SURROGATE: push_utf8(21'($urandom_range(CP_SURR_HI, CP_SURR_LO)), 3);
									F_TOO_HIGH: push_utf8(21'($urandom_range(21'h1fffff, 21'h110000)), 4);
									default: ;
								endcase
							end
							if (c < nchar)
								add_char();
						end
					end
				end
				if (fault == F_TRAIL_SLASH)
					path_buf.push_back(CH_SLASH);
			end
			random_fed += path_buf.size();
			flush_path();
			// hold the sender once until every verdict is back
			if (!paused && random_fed >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
